@@ rtl/rrte_pkg.sv @@
package rrte_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int MAX_RESULTS     = 32;
  localparam int TIMER_W         = 4;
  localparam int CFG_IDX_W       = 2;

  localparam logic [4:0] METRIC_INF = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRESH_TIMER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POISON_TIMER = 2'd1;

  localparam logic [TIMER_W-1:0] FRESH_TIMER_RST  = 4'd10;
  localparam logic [TIMER_W-1:0] POISON_TIMER_RST = 4'd5;

  localparam logic [1:0] STAT_LIVE = 2'd1;
  localparam logic [1:0] STAT_DEAD = 2'd2;

  localparam logic [2:0] OC_ADDED     = 3'd0;
  localparam logic [2:0] OC_REFRESHED = 3'd1;
  localparam logic [2:0] OC_POISONED  = 3'd2;
  localparam logic [2:0] OC_REPLACED  = 3'd3;
  localparam logic [2:0] OC_IGNORED   = 3'd4;
  localparam logic [2:0] OC_FULL      = 3'd5;
  localparam logic [2:0] OC_ADV_ENTRY = 3'd6;
  localparam logic [2:0] OC_ADV_EMPTY = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [31:0] dest_ip;
    logic [31:0] subnet_mask;
    logic [4:0]  metric_in;
    logic [31:0] sender_ip;
    logic [1:0]  port_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [31:0] adv_ip;
    logic [31:0] adv_mask;
    logic [4:0]  adv_metric;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        dest;
    logic [31:0]        mask;
    logic [4:0]         metric;
    logic [1:0]         port;
    logic [31:0]        next_hop;
    logic [1:0]         status;
    logic [TIMER_W-1:0] timer;
  } route_entry_t;

  typedef struct packed {
    logic [TIMER_W-1:0] fresh;
    logic [TIMER_W-1:0] poison;
  } timers_t;

endpackage

@@ rtl/rrte_mem.sv @@
module rrte_mem #(
  parameter int DEPTH = rrte_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output rrte_pkg::route_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  rrte_pkg::route_entry_t wr_data
);
  import rrte_pkg::*;

  route_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/rrte_seq.sv @@
module rrte_seq #(
  parameter int DEPTH = rrte_pkg::TABLE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int KW = $clog2(rrte_pkg::MAX_RESULTS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rrte_pkg::in_word_t     in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rrte_pkg::out_word_t    out_data,
  input  rrte_pkg::timers_t      timers,
  output logic                   mem_rd_en,
  output logic [AW-1:0]          mem_rd_addr,
  input  rrte_pkg::route_entry_t mem_rd_data,
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output rrte_pkg::route_entry_t mem_wr_data
);
  import rrte_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_DEC, S_ADV, S_ADV_END} state_t;

  state_t       state_r, state_nxt;
  in_word_t     item_r, item_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic         hit_r, hit_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [KW-1:0] k_r, k_nxt;
  out_word_t    held_r, held_nxt;
  logic         held_v_r, held_v_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_word_t    out_r, out_nxt;

  logic         out_free;
  logic         load;
  out_word_t    load_word;
  logic         idx_last;
  logic [AW-1:0] idx_inc;
  logic         qual;
  logic [4:0]   adv_met;
  route_entry_t e;

  assign e        = mem_rd_data;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_last = (CW'(idx_r) + CW'(1)) == count_r;
  assign idx_inc  = idx_r + AW'(1);
  assign qual     = e.port != item_r.port_in;
  assign adv_met  = (e.metric >= METRIC_INF) ? METRIC_INF : e.metric + 5'd1;
  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    held_nxt    = held_r;
    held_v_nxt  = held_v_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r;
    mem_wr_data = e;
    load        = 1'b0;
    load_word   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.metric_in > METRIC_INF) begin
            item_nxt.metric_in = METRIC_INF;
          end
          idx_nxt    = '0;
          k_nxt      = '0;
          hit_nxt    = 1'b0;
          held_v_nxt = 1'b0;
          if (count_r == '0) begin
            state_nxt = in_data.kind ? S_ADV_END : S_DEC;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_nxt   = in_data.kind ? S_ADV : S_SRCH;
          end
        end
      end

      S_SRCH: begin
        if (e.dest == item_r.dest_ip) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DEC;
        end else if (idx_last) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DEC;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_inc;
          idx_nxt     = idx_inc;
        end
      end

      // read data still holds the matched entry here
      S_DEC: begin
        if (out_free) begin
          load           = 1'b1;
          load_word.last = 1'b1;
          state_nxt      = S_IDLE;
          if (hit_r) begin
            if (e.next_hop == item_r.sender_ip) begin
              if (item_r.metric_in == METRIC_INF) begin
                if (e.status == STAT_DEAD) begin
                  load_word.outcome = OC_IGNORED;
                end else begin
                  load_word.outcome  = OC_POISONED;
                  mem_wr_en          = 1'b1;
                  mem_wr_data.metric = METRIC_INF;
                  mem_wr_data.status = STAT_DEAD;
                  mem_wr_data.timer  = timers.poison;
                end
              end else begin
                load_word.outcome  = OC_REFRESHED;
                mem_wr_en          = 1'b1;
                mem_wr_data.metric = item_r.metric_in;
                mem_wr_data.status = STAT_LIVE;
                mem_wr_data.timer  = timers.fresh;
              end
            end else if (item_r.metric_in == METRIC_INF || item_r.metric_in >= e.metric) begin
              load_word.outcome = OC_IGNORED;
            end else begin
              load_word.outcome    = OC_REPLACED;
              mem_wr_en            = 1'b1;
              mem_wr_data.metric   = item_r.metric_in;
              mem_wr_data.port     = item_r.port_in;
              mem_wr_data.next_hop = item_r.sender_ip;
              mem_wr_data.status   = STAT_LIVE;
              mem_wr_data.timer    = timers.fresh;
            end
          end else if (item_r.metric_in == METRIC_INF) begin
            load_word.outcome = OC_IGNORED;
          end else if (count_r == CW'(DEPTH)) begin
            load_word.outcome = OC_FULL;
          end else begin
            load_word.outcome = OC_ADDED;
            mem_wr_en         = 1'b1;
            mem_wr_addr       = count_r[AW-1:0];
            mem_wr_data.dest     = item_r.dest_ip;
            mem_wr_data.mask     = item_r.subnet_mask;
            mem_wr_data.metric   = item_r.metric_in;
            mem_wr_data.port     = item_r.port_in;
            mem_wr_data.next_hop = item_r.sender_ip;
            mem_wr_data.status   = STAT_LIVE;
            mem_wr_data.timer    = timers.fresh;
            count_nxt            = count_r + CW'(1);
          end
        end
      end

      // one entry held back so the final word can carry last
      S_ADV: begin
        if (!(qual && held_v_r && !out_free)) begin
          if (qual) begin
            if (held_v_r) begin
              load      = 1'b1;
              load_word = held_r;
            end
            held_nxt.outcome    = OC_ADV_ENTRY;
            held_nxt.adv_ip     = e.dest;
            held_nxt.adv_mask   = e.mask;
            held_nxt.adv_metric = adv_met;
            held_nxt.last       = 1'b0;
            held_v_nxt          = 1'b1;
            k_nxt               = k_r + KW'(1);
          end
          if (idx_last || (qual && k_r == KW'(MAX_RESULTS - 1))) begin
            state_nxt = S_ADV_END;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_inc;
            idx_nxt     = idx_inc;
          end
        end
      end

      S_ADV_END: begin
        if (out_free) begin
          load = 1'b1;
          if (held_v_r) begin
            load_word = held_r;
          end else begin
            load_word.outcome = OC_ADV_EMPTY;
          end
          load_word.last = 1'b1;
          held_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);
  assign out_nxt       = load ? load_word : out_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
      item_r      <= item_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      k_r         <= k_nxt;
      held_r      <= held_nxt;
      out_r       <= out_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("route count beyond table depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("table read and write in the same cycle");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.outcome != OC_ADV_ENTRY) |-> out_r.last)
    else $error("update result word without last");

  a_held_scope: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> (state_r == S_ADV || state_r == S_ADV_END))
    else $error("held advert word outside advert scan");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_r))
    else $error("output word overwritten while waiting");

endmodule

@@ rtl/rip_route_table_engine_top.sv @@
// update word: table entries read from entry 0 until the destination matches or the last route, then one result word
// advert word: table scanned from entry 0 up to the last result, at most one word per table read
// throughput: one word in flight; the next is taken once the last result is in the output register
// one table read per cycle while scanning; output stall holds the advert scan and the update result
// reset: route count cleared, timers back to 10 and 5, table contents left undefined
module rip_route_table_engine_top #(
  parameter int TABLE_DEPTH = rrte_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rrte_pkg::in_word_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rrte_pkg::out_word_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rrte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrte_pkg::TIMER_W-1:0]      cfg_data
);
  import rrte_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  timers_t      timers_r, timers_nxt;
  logic         mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  route_entry_t mem_rd_data;
  logic         mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  route_entry_t mem_wr_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    timers_nxt = timers_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRESH_TIMER:  timers_nxt.fresh  = cfg_data;
        CFG_POISON_TIMER: timers_nxt.poison = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timers_r.fresh  <= FRESH_TIMER_RST;
      timers_r.poison <= POISON_TIMER_RST;
    end else begin
      timers_r <= timers_nxt;
    end
  end

  rrte_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  rrte_seq #(.DEPTH(TABLE_DEPTH)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .timers      (timers_r),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

endmodule
